>>> rtl/lcdnr_pkg.sv
package lcdnr_pkg;

   localparam int ADDR_W = 7;
   localparam int BYTE_W = 8;
   localparam int ADDR_SPAN = 1 << ADDR_W;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] bus_byte;
      logic              read_from_cgram;
      logic [ADDR_W-1:0] read_address;
   } req_type;

   typedef struct packed {
      logic              byte_done;
      logic [BYTE_W-1:0] byte_value;
      logic              was_data;
      logic [1:0]        entry_mode;
      logic [2:0]        display_control;
      logic [3:0]        shift_setting;
      logic [4:0]        function_setting;
      logic [ADDR_W-1:0] current_address;
      logic              cgram_selected;
      logic [BYTE_W-1:0] read_data;
   } rsp_type;

   // completed-byte report from the nibble receiver
   typedef struct packed {
      logic              done;
      logic [BYTE_W-1:0] value;
      logic              is_data;
   } rx_result_type;

   typedef struct packed {
      logic              en;
      logic              glyph;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic              glyph;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef logic [ADDR_W-1:0] mod_tbl_type [ADDR_SPAN];

   // address-to-entry table, evaluated at elaboration only
   function automatic mod_tbl_type mod_table(input int depth);
      mod_tbl_type t;
      int          r;
      for (int i = 0; i < ADDR_SPAN; i++) begin
         r = i;
         for (int k = 0; k < ADDR_SPAN; k++) begin
            if (r >= depth) begin
               r = r - depth;
            end
         end
         t[i] = ADDR_W'(r);
      end
      return t;
   endfunction

endpackage

>>> rtl/char_lcd_nibble_receiver_top.sv
// Character LCD receiver, expander-fed 4-bit interface.
// Input channel req_valid/req_ready/req_word carries one word per item: either a
// bus byte written by the master (op 0) or a request to read one RAM entry (op 1).
// Result channel rsp_valid/rsp_ready/rsp_word returns exactly one word per item,
// holding the assembled byte (if this word completed one), the stored mode
// fields, the address counter and RAM select as they stand after the item, and
// the RAM entry for a read.
// Timing: a bus byte gives its result the cycle after acceptance; a read first
// passes through the registered RAM read and the read state. A clear-display
// command sweeps the display RAM one entry per cycle, and its result is loaded
// at the end of the sweep; no item is taken during the sweep.
// Throughput: one bus byte per cycle while the result side keeps up; no new
// item is taken while a read is in the read state. One item is in flight at a
// time; the single result register and the read and clear states set this.
// Reset (synchronous, active high) clears the nibble receiver, the mode fields,
// the address counter and the RAM valid bits: every RAM entry reads as zero
// afterwards, with no clearing pass.
// If the result side stalls, the finished word waits in the result register and
// req_ready drops until it is taken.
module char_lcd_nibble_receiver_top
   import lcdnr_pkg::*;
#(
   parameter int DISPLAY_DEPTH = 128,
   parameter int GLYPH_DEPTH   = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int DAW = $clog2(DISPLAY_DEPTH);

   localparam mod_tbl_type DISP_MOD  = mod_table(DISPLAY_DEPTH);
   localparam mod_tbl_type GLYPH_MOD = mod_table(GLYPH_DEPTH);

   localparam logic [ADDR_W-1:0] DISP_LAST  = ADDR_W'(DISPLAY_DEPTH - 1);
   localparam logic [ADDR_W-1:0] GLYPH_LAST = ADDR_W'(GLYPH_DEPTH - 1);
   localparam logic [DAW-1:0]    CLR_LAST   = DAW'(DISPLAY_DEPTH - 1);

   // instruction codes and masks
   localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_HOME   = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_ENTRY  = 8'h04;
   localparam logic [BYTE_W-1:0] CMD_DISP   = 8'h08;
   localparam logic [BYTE_W-1:0] CMD_SHIFT  = 8'h10;
   localparam logic [BYTE_W-1:0] CMD_FUNC   = 8'h20;
   localparam logic [BYTE_W-1:0] CMD_CGADDR = 8'h40;
   localparam logic [BYTE_W-1:0] MASK_HOME  = 8'hFE;
   localparam logic [BYTE_W-1:0] MASK_ENTRY = 8'hFC;
   localparam logic [BYTE_W-1:0] MASK_DISP  = 8'hF8;
   localparam logic [BYTE_W-1:0] MASK_SHIFT = 8'hF0;
   localparam logic [BYTE_W-1:0] MASK_FUNC  = 8'hE0;
   localparam logic [BYTE_W-1:0] MASK_CG    = 8'hC0;
   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CLEAR} state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_word_ff;
   logic [1:0]        entry_ff, entry_in;
   logic [2:0]        disp_ff, disp_in;
   logic [3:0]        shift_ff, shift_in;
   logic [4:0]        func_ff, func_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              gsel_ff, gsel_in;
   logic [DAW-1:0]    clr_ff;

   logic              accept;
   logic              rx_step;
   logic              clear_start;
   logic              rsp_load;
   logic [ADDR_W-1:0] wr_idx;
   logic [BYTE_W-1:0] d;
   rx_result_type     rx_res;
   mem_wr_type        mem_wr;
   mem_rd_type        mem_rd;
   logic [BYTE_W-1:0] mem_rd_data;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rx_step   = accept && !req_word.op;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign d         = rx_res.value;

   // result register loads: plain bus byte, end of read, end of clear sweep
   assign rsp_load = (rx_step && !clear_start) ||
                     (state_ff == ST_READ) ||
                     ((state_ff == ST_CLEAR) && (clr_ff == CLR_LAST));

   lcdnr_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .step_en  (rx_step),
      .bus_byte (req_word.bus_byte),
      .result   (rx_res)
   );

   lcdnr_mem #(
      .DISPLAY_DEPTH (DISPLAY_DEPTH),
      .GLYPH_DEPTH   (GLYPH_DEPTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rd_data)
   );

   // next state of the controller registers and RAM port requests
   always_comb begin
      entry_in    = entry_ff;
      disp_in     = disp_ff;
      shift_in    = shift_ff;
      func_in     = func_ff;
      addr_in     = addr_ff;
      gsel_in     = gsel_ff;
      clear_start = 1'b0;
      mem_wr      = '0;
      mem_rd      = '0;
      wr_idx      = gsel_ff ? GLYPH_MOD[addr_ff] : DISP_MOD[addr_ff];

      if (accept && req_word.op) begin
         mem_rd.en    = 1'b1;
         mem_rd.glyph = req_word.read_from_cgram;
         mem_rd.addr  = req_word.read_from_cgram ? GLYPH_MOD[req_word.read_address]
                                                 : DISP_MOD[req_word.read_address];
      end

      if (rx_step && rx_res.done) begin
         if (rx_res.is_data) begin
            // data word: store at counter, advance with wrap
            mem_wr.en    = 1'b1;
            mem_wr.glyph = gsel_ff;
            mem_wr.addr  = wr_idx;
            mem_wr.data  = d;
            if (wr_idx == (gsel_ff ? GLYPH_LAST : DISP_LAST)) begin
               addr_in = '0;
            end else begin
               addr_in = wr_idx + ADDR_W'(1);
            end
         end else begin
            priority if (d == CMD_CLEAR) begin
               clear_start = 1'b1;
               addr_in     = '0;
               gsel_in     = 1'b0;
            end else if ((d & MASK_HOME) == CMD_HOME) begin
               addr_in  = '0;
               gsel_in  = 1'b0;
               shift_in = '0;
            end else if ((d & MASK_ENTRY) == CMD_ENTRY) begin
               entry_in = d[1:0];
            end else if ((d & MASK_DISP) == CMD_DISP) begin
               disp_in = d[2:0];
            end else if ((d & MASK_SHIFT) == CMD_SHIFT) begin
               shift_in = d[3:0];
            end else if ((d & MASK_FUNC) == CMD_FUNC) begin
               func_in = d[4:0];
            end else if ((d & MASK_CG) == CMD_CGADDR) begin
               addr_in = {1'b0, d[5:0]};
               gsel_in = 1'b1;
            end else if (d[7]) begin
               addr_in = d[6:0];
               gsel_in = 1'b0;
            end else begin
               // null instruction: nothing changes
            end
         end
      end

      if (state_ff == ST_CLEAR) begin
         mem_wr.en    = 1'b1;
         mem_wr.glyph = 1'b0;
         mem_wr.addr  = ADDR_W'(clr_ff);
         mem_wr.data  = SPACE_CHAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         entry_ff     <= '0;
         disp_ff      <= '0;
         shift_ff     <= '0;
         func_ff      <= '0;
         addr_ff      <= '0;
         gsel_ff      <= 1'b0;
         clr_ff       <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  entry_ff <= entry_in;
                  disp_ff  <= disp_in;
                  shift_ff <= shift_in;
                  func_ff  <= func_in;
                  addr_ff  <= addr_in;
                  gsel_ff  <= gsel_in;
                  if (req_word.op) begin
                     state_ff <= ST_READ;
                  end else if (clear_start) begin
                     state_ff <= ST_CLEAR;
                     clr_ff   <= '0;
                  end else begin
                     rsp_word_ff.byte_done        <= rx_res.done;
                     rsp_word_ff.byte_value       <= rx_res.done ? d : '0;
                     rsp_word_ff.was_data         <= rx_res.done && rx_res.is_data;
                     rsp_word_ff.entry_mode       <= entry_in;
                     rsp_word_ff.display_control  <= disp_in;
                     rsp_word_ff.shift_setting    <= shift_in;
                     rsp_word_ff.function_setting <= func_in;
                     rsp_word_ff.current_address  <= addr_in;
                     rsp_word_ff.cgram_selected   <= gsel_in;
                     rsp_word_ff.read_data        <= '0;
                  end
               end
            end
            ST_READ: begin
               state_ff                     <= ST_IDLE;
               rsp_word_ff.byte_done        <= 1'b0;
               rsp_word_ff.byte_value       <= '0;
               rsp_word_ff.was_data         <= 1'b0;
               rsp_word_ff.entry_mode       <= entry_ff;
               rsp_word_ff.display_control  <= disp_ff;
               rsp_word_ff.shift_setting    <= shift_ff;
               rsp_word_ff.function_setting <= func_ff;
               rsp_word_ff.current_address  <= addr_ff;
               rsp_word_ff.cgram_selected   <= gsel_ff;
               rsp_word_ff.read_data        <= mem_rd_data;
            end
            ST_CLEAR: begin
               clr_ff <= clr_ff + DAW'(1);
               if (clr_ff == CLR_LAST) begin
                  state_ff                     <= ST_IDLE;
                  rsp_word_ff.byte_done        <= 1'b1;
                  rsp_word_ff.byte_value       <= CMD_CLEAR;
                  rsp_word_ff.was_data         <= 1'b0;
                  rsp_word_ff.entry_mode       <= entry_ff;
                  rsp_word_ff.display_control  <= disp_ff;
                  rsp_word_ff.shift_setting    <= shift_ff;
                  rsp_word_ff.function_setting <= func_ff;
                  rsp_word_ff.current_address  <= addr_ff;
                  rsp_word_ff.cgram_selected   <= gsel_ff;
                  rsp_word_ff.read_data        <= '0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // read request returns its word once the read state has loaded the result register
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.op) |=> ##1 rsp_valid)
      else $error("read result not delivered on time");

   // plain bus byte returns its word on the next edge
   a_write_latency: assert property (@(posedge clock) disable iff (reset)
      (rx_step && !clear_start) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("bus byte result missing");

   // no RAM write competes with a pending read
   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !mem_wr.en)
      else $error("RAM write during read");

   // clear sweep ends with its result and an idle controller
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_ff == CLR_LAST) |=>
         (rsp_valid && state_ff == ST_IDLE && rsp_word.byte_value == CMD_CLEAR))
      else $error("clear sweep did not finish cleanly");

endmodule

>>> rtl/lcdnr_rx.sv
module lcdnr_rx
   import lcdnr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [BYTE_W-1:0] bus_byte,
   output rx_result_type     result
);

   localparam logic [BYTE_W-1:0] EN_MASK = 8'h04;
   localparam logic [BYTE_W-1:0] HI_MASK = 8'hF0;

   // flag bits: high cap/en-high/en-low, low cap/en-high/en-low
   localparam int F_HCAP = 0;
   localparam int F_HEH  = 1;
   localparam int F_HEL  = 2;
   localparam int F_LCAP = 3;
   localparam int F_LEH  = 4;
   localparam int F_LEL  = 5;

   logic [BYTE_W-1:0] hcap_ff, hcap_in;
   logic [BYTE_W-1:0] lcap_ff, lcap_in;
   logic [5:0]        flags_ff, flags_in;
   logic              low_done;

   always_comb begin
      hcap_in  = hcap_ff;
      lcap_in  = lcap_ff;
      flags_in = flags_ff;
      low_done = 1'b0;
      if (step_en) begin
         if (!(flags_ff[F_HEH] && flags_ff[F_HEL])) begin
            priority if (!flags_ff[F_HCAP]) begin
               hcap_in          = bus_byte;
               flags_in[F_HCAP] = 1'b1;
            end else if (!flags_ff[F_HEH] && ((hcap_ff | EN_MASK) == bus_byte)) begin
               flags_in[F_HEH] = 1'b1;
            end else if (!flags_ff[F_HEL] && ((hcap_ff & ~EN_MASK) == bus_byte)) begin
               flags_in[F_HEL] = 1'b1;
            end else begin
               // stray byte: dropped
            end
         end else begin
            priority if (!flags_ff[F_LCAP]) begin
               lcap_in          = bus_byte;
               flags_in[F_LCAP] = 1'b1;
            end else if (!flags_ff[F_LEH] && ((lcap_ff | EN_MASK) == bus_byte)) begin
               flags_in[F_LEH] = 1'b1;
            end else if (!flags_ff[F_LEL] && ((lcap_ff & ~EN_MASK) == bus_byte)) begin
               flags_in[F_LEL] = 1'b1;
            end else begin
               // stray byte: dropped
            end
            low_done = flags_in[F_LEH] && flags_in[F_LEL];
         end
      end
      result.done    = low_done;
      result.value   = (hcap_ff & HI_MASK) | (lcap_in >> 4);
      result.is_data = hcap_ff[0];
      if (low_done) begin
         flags_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcap_ff  <= '0;
         lcap_ff  <= '0;
         flags_ff <= '0;
      end else begin
         hcap_ff  <= hcap_in;
         lcap_ff  <= lcap_in;
         flags_ff <= flags_in;
      end
   end

endmodule

>>> rtl/lcdnr_mem.sv
module lcdnr_mem
   import lcdnr_pkg::*;
#(
   parameter int DISPLAY_DEPTH = 128,
   parameter int GLYPH_DEPTH   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  mem_wr_type        wr,
   input  mem_rd_type        rd,
   output logic [BYTE_W-1:0] rd_data
);

   localparam int DAW = $clog2(DISPLAY_DEPTH);
   localparam int GAW = $clog2(GLYPH_DEPTH);

   logic [BYTE_W-1:0] disp_mem  [DISPLAY_DEPTH];
   logic [BYTE_W-1:0] glyph_mem [GLYPH_DEPTH];
   logic [DISPLAY_DEPTH-1:0] disp_vld_ff;
   logic [GLYPH_DEPTH-1:0]   glyph_vld_ff;
   logic [BYTE_W-1:0] disp_q_ff, glyph_q_ff;
   logic              disp_hit_ff, glyph_hit_ff, sel_glyph_ff;

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_vld_ff  <= '0;
         glyph_vld_ff <= '0;
      end else if (wr.en) begin
         if (wr.glyph) begin
            glyph_vld_ff[wr.addr[GAW-1:0]] <= 1'b1;
         end else begin
            disp_vld_ff[wr.addr[DAW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && !wr.glyph) begin
         disp_mem[wr.addr[DAW-1:0]] <= wr.data;
      end
      if (rd.en) begin
         disp_q_ff <= disp_mem[rd.addr[DAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.glyph) begin
         glyph_mem[wr.addr[GAW-1:0]] <= wr.data;
      end
      if (rd.en) begin
         glyph_q_ff <= glyph_mem[rd.addr[GAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         sel_glyph_ff <= rd.glyph;
         disp_hit_ff  <= disp_vld_ff[rd.addr[DAW-1:0]];
         glyph_hit_ff <= glyph_vld_ff[rd.addr[GAW-1:0]];
      end
   end

   always_comb begin
      if (sel_glyph_ff) begin
         rd_data = glyph_hit_ff ? glyph_q_ff : '0;
      end else begin
         rd_data = disp_hit_ff ? disp_q_ff : '0;
      end
   end

endmodule

>>> dv/tb_top.sv
module tb_top;
   import lcdnr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Same depths as the block's defaults; the shadow RAMs below use them too.
   localparam int DISP_DEPTH  = 128;
   localparam int GLYPH_DEPTH = 64;

   // Item kinds on the request channel.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Instruction bases (RS = 0). The low bits are the payload of each class.
   localparam logic [7:0] INS_NOP        = 8'h00;
   localparam logic [7:0] INS_CLEAR      = 8'h01;
   localparam logic [7:0] INS_HOME       = 8'h02;
   localparam logic [7:0] INS_ENTRY      = 8'h04;
   localparam logic [7:0] INS_DISPLAY    = 8'h08;
   localparam logic [7:0] INS_SHIFT      = 8'h10;
   localparam logic [7:0] INS_FUNCTION   = 8'h20;
   localparam logic [7:0] INS_CGRAM_ADDR = 8'h40;
   localparam logic [7:0] INS_DDRAM_ADDR = 8'h80;

   localparam logic [7:0] EN_BIT     = 8'h04;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // Receiver progress bits: capture / enable-high copy / enable-low copy,
   // for the high phase and then the low phase.
   localparam int FL_HCAP = 0;
   localparam int FL_HEH  = 1;
   localparam int FL_HEL  = 2;
   localparam int FL_LCAP = 3;
   localparam int FL_LEH  = 4;
   localparam int FL_LEL  = 5;

   localparam int RANDOM_WORDS = 600;
   localparam int LONG_HOLD    = 150;
   // A clear sweeps all of display RAM before its result shows up.
   localparam int END_DRAIN    = DISP_DEPTH + 40;
   // Slowest legal run: ~700 words, each with the longest gap, a clear-length
   // stall and a sparse receiver, plus the long holds. Taken several times over.
   localparam int LIMIT_CYCLES = 600000;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   // One row of the directed table: the word and, where it is obvious, the
   // result typed in by hand. Rows without one go through the shadow model.
   typedef struct packed {
      req_type word;
      logic    typed;
      rsp_type result;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   // Travels next to req_word so the acceptance monitor knows which
   // expectation to queue.
   logic    cur_typed = 1'b0;
   rsp_type cur_typed_rsp = '0;

   rsp_type     pending_rsp_q[$];
   dir_row_type directed_q[$];
   int          mismatch_count = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   int          cycle_count = 0;
   bit          hold_request = 1'b0;

   // ---------------------------------------------------------------------
   // Shadow of the receiver and controller state
   // ---------------------------------------------------------------------
   logic [7:0] rx_hi = '0;
   logic [7:0] rx_lo = '0;
   logic [5:0] rx_flags = '0;
   logic [7:0] shadow_disp [DISP_DEPTH] = '{default: '0};
   logic [7:0] shadow_glyph [GLYPH_DEPTH] = '{default: '0};
   logic [6:0] shadow_addr = '0;
   logic       shadow_cgsel = 1'b0;
   logic [1:0] shadow_entry = '0;
   logic [2:0] shadow_dctl = '0;
   logic [3:0] shadow_shift = '0;
   logic [4:0] shadow_func = '0;

   always #5 clock = ~clock;

   char_lcd_nibble_receiver_top #(
      .DISPLAY_DEPTH(DISP_DEPTH),
      .GLYPH_DEPTH  (GLYPH_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

   // Moves one phase of the nibble receiver; true once both enable copies of
   // that phase have been seen. Bytes matching neither copy fall through.
   function automatic bit nibble_phase(bit low_phase, logic [7:0] b);
      int         base;
      logic [7:0] cap;
      base = low_phase ? FL_LCAP : FL_HCAP;
      cap  = low_phase ? rx_lo : rx_hi;
      if (!rx_flags[base]) begin
         if (low_phase) rx_lo = b;
         else rx_hi = b;
         rx_flags[base] = 1'b1;
      end else if (!rx_flags[base+1] && (cap | EN_BIT) == b) begin
         rx_flags[base+1] = 1'b1;
      end else if (!rx_flags[base+2] && (cap & ~EN_BIT) == b) begin
         rx_flags[base+2] = 1'b1;
      end
      return rx_flags[base+1] && rx_flags[base+2];
   endfunction

   // Applies one accepted word to the shadow state and returns the result
   // word the block must produce for it.
   function automatic rsp_type lcd_expected_word(req_type w);
      rsp_type    r;
      logic [7:0] d;
      int         depth;
      int         idx;
      r = '0;
      if (w.op == OP_READ) begin
         // reads never move the bus receiver
         r.read_data = w.read_from_cgram ? shadow_glyph[w.read_address % GLYPH_DEPTH]
                                         : shadow_disp[w.read_address % DISP_DEPTH];
      end else if (!(rx_flags[FL_HEH] && rx_flags[FL_HEL])) begin
         void'(nibble_phase(1'b0, w.bus_byte));
      end else if (nibble_phase(1'b1, w.bus_byte)) begin
         d = {rx_hi[7:4], rx_lo[7:4]};
         r.byte_done  = 1'b1;
         r.byte_value = d;
         r.was_data   = rx_hi[0];
         if (rx_hi[0]) begin
            // data write: counter taken modulo the selected depth, then wraps
            depth = shadow_cgsel ? GLYPH_DEPTH : DISP_DEPTH;
            idx   = shadow_addr % depth;
            if (shadow_cgsel) shadow_glyph[idx] = d;
            else shadow_disp[idx] = d;
            idx++;
            if (idx >= depth) idx = 0;
            shadow_addr = 7'(idx);
         end else if (d == INS_CLEAR) begin
            foreach (shadow_disp[i]) shadow_disp[i] = SPACE_CHAR;
            shadow_addr  = '0;
            shadow_cgsel = 1'b0;
         end else if ((d & 8'hFE) == INS_HOME) begin
            shadow_addr  = '0;
            shadow_cgsel = 1'b0;
            shadow_shift = '0;
         end else if ((d & 8'hFC) == INS_ENTRY) begin
            shadow_entry = d[1:0];
         end else if ((d & 8'hF8) == INS_DISPLAY) begin
            shadow_dctl = d[2:0];
         end else if ((d & 8'hF0) == INS_SHIFT) begin
            shadow_shift = d[3:0];
         end else if ((d & 8'hE0) == INS_FUNCTION) begin
            shadow_func = d[4:0];
         end else if ((d & 8'hC0) == INS_CGRAM_ADDR) begin
            shadow_addr  = {1'b0, d[5:0]};
            shadow_cgsel = 1'b1;
         end else if ((d & INS_DDRAM_ADDR) != INS_NOP) begin
            shadow_addr  = d[6:0];
            shadow_cgsel = 1'b0;
         end
         // the null instruction lands here with nothing changed
         rx_flags = '0;
      end
      r.entry_mode       = shadow_entry;
      r.display_control  = shadow_dctl;
      r.shift_setting    = shadow_shift;
      r.function_setting = shadow_func;
      r.current_address  = shadow_addr;
      r.cgram_selected   = shadow_cgsel;
      return r;
   endfunction

   function automatic req_type bus_word(logic [7:0] b);
      req_type w;
      w.op              = OP_WRITE;
      w.bus_byte        = b;
      // ignored on a bus write, so let them toggle
      w.read_from_cgram = 1'($urandom);
      w.read_address    = 7'($urandom);
      return w;
   endfunction

   function automatic req_type read_word(logic cg, logic [6:0] a);
      req_type w;
      w.op              = OP_READ;
      w.bus_byte        = 8'($urandom);
      w.read_from_cgram = cg;
      w.read_address    = a;
      return w;
   endfunction

   function automatic rsp_type hand_result(logic done, logic [7:0] value, logic is_data,
                                           logic [6:0] addr, logic [7:0] rdata);
      rsp_type r;
      r                 = '0;
      r.byte_done       = done;
      r.byte_value      = value;
      r.was_data        = is_data;
      r.current_address = addr;
      r.read_data       = rdata;
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender: one word per call, held until accepted, then maybe a gap.
   // Bursts of random length; now and then a long burst with no idling.
   // ---------------------------------------------------------------------
   task automatic offer_word(req_type w, bit typed, rsp_type want, bit counts);
      int gap;
      req_word      <= w;
      req_valid     <= 1'b1;
      cur_typed     <= typed;
      cur_typed_rsp <= want;
      do @(posedge clock); while (!req_ready);
      if (counts) words_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(0, 15);
      end
   endtask

   task automatic offer_plain(req_type w, bit counts);
      offer_word(w, 1'b0, '0, counts);
   endtask

   // Before a word: maybe a read (never moves the receiver) and, on noisy
   // sequences, maybe a stray byte that the receiver should drop.
   task automatic maybe_noise(bit noisy);
      if ($urandom_range(0, 9) == 0) offer_plain(read_word(1'($urandom), 7'($urandom)), 1'b1);
      if (noisy && $urandom_range(0, 3) == 0) offer_plain(bus_word(8'($urandom)), 1'b0);
   endtask

   // Capture word, then the two enable copies in random order.
   task automatic send_nibble(logic [3:0] nib, logic rs, bit high_half, bit noisy);
      logic [7:0] cap;
      bit         en_first;
      cap = {nib, 4'($urandom)};
      if (high_half) cap[0] = rs;
      en_first = 1'($urandom);
      maybe_noise(noisy);
      offer_plain(bus_word(cap), 1'b1);
      maybe_noise(noisy);
      offer_plain(bus_word(en_first ? (cap | EN_BIT) : (cap & ~EN_BIT)), 1'b1);
      maybe_noise(noisy);
      offer_plain(bus_word(en_first ? (cap & ~EN_BIT) : (cap | EN_BIT)), 1'b1);
   endtask

   task automatic send_lcd_byte(logic [7:0] d, logic rs, bit noisy);
      send_nibble(d[7:4], rs, 1'b1, noisy);
      send_nibble(d[3:0], rs, 1'b0, noisy);
   endtask

   // Picks a byte class with data writes and address moves dominant; clears
   // are kept rare since each one stalls the block for a full sweep.
   task automatic send_random_byte();
      int         pick;
      logic [7:0] d;
      logic       rs;
      pick = $urandom_range(0, 99);
      d    = 8'($urandom);
      rs   = 1'b0;
      if (pick < 45) rs = 1'b1;
      else if (pick < 52) d = INS_DDRAM_ADDR | d;
      else if (pick < 58) d = INS_CGRAM_ADDR | (d & 8'h3F);
      else if (pick < 63) d = INS_ENTRY | (d & 8'h03);
      else if (pick < 68) d = INS_DISPLAY | (d & 8'h07);
      else if (pick < 73) d = INS_SHIFT | (d & 8'h0F);
      else if (pick < 78) d = INS_FUNCTION | (d & 8'h1F);
      else if (pick < 82) d = INS_HOME | (d & 8'h01);
      else if (pick < 84) d = INS_CLEAR;
      else if (pick < 87) d = INS_NOP;
      else rs = 1'($urandom);
      send_lcd_byte(d, rs, $urandom_range(0, 4) == 0);
   endtask

   // always lets at least one edge pass so valid is never driven twice at once
   task automatic wait_drained();
      do @(negedge clock); while (pending_rsp_q.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Acceptance and result monitor, all on the rising edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp_q.size() == 0) begin
               $display("%0t: result word with nothing pending: %h", $time, rsp_word);
               mismatch_count++;
            end else begin
               want = pending_rsp_q.pop_front();
               check_field("byte_done", 8'(want.byte_done), 8'(rsp_word.byte_done));
               check_field("byte_value", want.byte_value, rsp_word.byte_value);
               check_field("was_data", 8'(want.was_data), 8'(rsp_word.was_data));
               check_field("entry_mode", 8'(want.entry_mode), 8'(rsp_word.entry_mode));
               check_field("display_control", 8'(want.display_control),
                           8'(rsp_word.display_control));
               check_field("shift_setting", 8'(want.shift_setting),
                           8'(rsp_word.shift_setting));
               check_field("function_setting", 8'(want.function_setting),
                           8'(rsp_word.function_setting));
               check_field("current_address", 8'(want.current_address),
                           8'(rsp_word.current_address));
               check_field("cgram_selected", 8'(want.cgram_selected),
                           8'(rsp_word.cgram_selected));
               check_field("read_data", want.read_data, rsp_word.read_data);
            end
         end
         if (req_valid && req_ready) begin
            // the shadow model always runs so its state tracks the block;
            // a hand-typed row overrides what gets compared
            want = lcd_expected_word(req_word);
            pending_rsp_q.push_back(cur_typed ? cur_typed_rsp : want);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall pattern changes per segment; a hold request from the
   // sender forces a long stretch of back-pressure.
   // ---------------------------------------------------------------------
   initial begin
      rx_mode_type mode;
      int          seg_left;
      int          hold_left;
      int          phase;
      mode      = RX_ALWAYS;
      seg_left  = 0;
      hold_left = 0;
      phase     = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (seg_left == 0) begin
            mode     = rx_mode_type'($urandom_range(0, 3));
            seg_left = $urandom_range(20, 120);
         end
         seg_left--;
         phase++;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               RX_ALWAYS:   rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= 1'($urandom);
               RX_SPARSE:   rsp_ready <= ($urandom_range(0, 4) == 0);
               RX_PERIODIC: rsp_ready <= (phase % 3 == 0);
               default:     rsp_ready <= 1'b1;
            endcase
         end
         @(negedge clock);
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      bit hold_done_a;
      bit hold_done_b;
      bit pause_done_a;
      bit pause_done_b;
      hold_done_a  = 1'b0;
      hold_done_b  = 1'b0;
      pause_done_a = 1'b0;
      pause_done_b = 1'b0;

      // Directed table. RAMs read zero straight out of reset; the null
      // instruction is wrapped with stray bytes in both phases; then the
      // top display address, a data write there that wraps the counter to
      // zero, and a read back of the entry.
      directed_q.push_back('{read_word(1'b0, 7'd127), 1'b1,
                             hand_result(1'b0, 8'h00, 1'b0, 7'd0, 8'h00)});
      directed_q.push_back('{read_word(1'b1, 7'd127), 1'b1,
                             hand_result(1'b0, 8'h00, 1'b0, 7'd0, 8'h00)});
      directed_q.push_back('{read_word(1'b1, 7'd0), 1'b1,
                             hand_result(1'b0, 8'h00, 1'b0, 7'd0, 8'h00)});
      // null instruction, high phase: capture, stray, enable high, enable low
      directed_q.push_back('{bus_word(8'h00), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'hFF), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'h04), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'h00), 1'b0, rsp_type'('0)});
      // low phase: capture, stray, enable low first, then enable high
      directed_q.push_back('{bus_word(8'h00), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'h13), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'h00), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'h04), 1'b1,
                             hand_result(1'b1, INS_NOP, 1'b0, 7'd0, 8'h00)});
      // display address 127
      directed_q.push_back('{bus_word(8'hF8), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'hFC), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'hF8), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'hF8), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'hF8), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'hFC), 1'b1,
                             hand_result(1'b1, 8'hFF, 1'b0, 7'd127, 8'h00)});
      // data 0xA5 at the last entry; counter wraps to zero
      directed_q.push_back('{bus_word(8'hAD), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'hA9), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'hAD), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'h5B), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'h5F), 1'b0, rsp_type'('0)});
      directed_q.push_back('{bus_word(8'h5B), 1'b1,
                             hand_result(1'b1, 8'hA5, 1'b1, 7'd0, 8'h00)});
      directed_q.push_back('{read_word(1'b0, 7'd127), 1'b1,
                             hand_result(1'b0, 8'h00, 1'b0, 7'd0, 8'hA5)});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_q[i]) begin
         offer_word(directed_q[i].word, directed_q[i].typed, directed_q[i].result, 1'b1);
      end

      // Random part: mostly whole bytes with random content; the rest are
      // truncated sequences and loose words that knock the receiver off step.
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 4)) offer_plain(bus_word(8'($urandom)), 1'b1);
         end else begin
            send_random_byte();
         end
         // long receiver hold while this side keeps offering
         if (!hold_done_a && words_sent >= 120) begin
            hold_done_a  = 1'b1;
            hold_request = 1'b1;
         end
         if (!hold_done_b && words_sent >= 430) begin
            hold_done_b  = 1'b1;
            hold_request = 1'b1;
         end
         // sender goes quiet until every outstanding result is back
         if (!pause_done_a && words_sent >= 260) begin
            pause_done_a = 1'b1;
            req_valid <= 1'b0;
            wait_drained();
         end
         if (!pause_done_b && words_sent >= 520) begin
            pause_done_b = 1'b1;
            req_valid <= 1'b0;
            wait_drained();
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      // allow for a trailing clear sweep or a stray extra word
      repeat (END_DRAIN) @(negedge clock);

      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
